// ===== rtl/fpst_pkg.sv =====
// shared widths, defaults and controller/datapath interface types
package fpst_pkg;

   localparam int POS_W          = 11;
   localparam int DELTA_W        = 16;
   localparam int SUM_W          = 32;
   localparam int TABLE_SIZE_DEF = 1024;

   typedef struct packed {
      logic clear;     // write zero at the sweep address and advance
      logic load;      // capture a new request beat
      logic step;      // read the entry at the walk pointer and advance it
      logic out_load;  // capture the final sum into the response register
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_done;
      logic is_query;
   } status_type;

endpackage

// ===== rtl/fpst_ram.sv =====
// generic single write port, single read port ram with registered read
module fpst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fpst_ctrl.sv =====
// controller state machine: clearing sweep, request acceptance, walk sequencing, response slot
module fpst_ctrl
   import fpst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!status.walk_done) begin
               cmd.step = 1'b1;
            end else if (!status.is_query) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               // response slot free or draining this cycle
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/fpst_dp.sv =====
// datapath: walk pointer, delta and accumulator registers, table ram, response register
module fpst_dp
   import fpst_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      req_operation,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DELTA_W-1:0] req_delta,
   output logic signed [SUM_W-1:0]   rsp_prefix_sum
);

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam int SPAN_W = $clog2(TABLE_SIZE + 1);
   // pointer holds any request position and one upward step past the table end
   localparam int PTR_W  = ((SPAN_W > POS_W) ? SPAN_W : POS_W) + 1;
   localparam logic [PTR_W-1:0]  PtrTop  = PTR_W'(TABLE_SIZE);
   localparam logic [ADDR_W-1:0] AddrTop = ADDR_W'(TABLE_SIZE - 1);

   logic [PTR_W-1:0]        pos_ff, pos_in;
   logic [SUM_W-1:0]        delta_ff;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic                    query_ff;
   logic                    rdv_ff;
   logic [ADDR_W-1:0]       wr_addr_ff;
   logic [ADDR_W-1:0]       clr_ff;
   logic signed [SUM_W-1:0] rsp_sum_ff;

   logic [PTR_W-1:0]  req_pos_ext;
   logic [PTR_W-1:0]  pos_low;
   logic [PTR_W-1:0]  pos_dec;
   logic [ADDR_W-1:0] rd_addr;
   logic [SUM_W-1:0]  rd_data;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [SUM_W-1:0]  ram_wdata;

   assign req_pos_ext = PTR_W'(req_position);
   assign pos_dec     = pos_ff - PTR_W'(1);
   assign pos_low     = pos_ff & (~pos_ff + PTR_W'(1));
   assign rd_addr     = pos_dec[ADDR_W-1:0];

   always_comb begin
      pos_in = pos_ff;
      if (cmd.load) begin
         // queries past the end see the whole table
         if (req_operation && (req_pos_ext > PtrTop)) begin
            pos_in = PtrTop;
         end else begin
            pos_in = req_pos_ext;
         end
      end else if (cmd.step) begin
         pos_in = query_ff ? (pos_ff & pos_dec) : (pos_ff + pos_low);
      end
   end

   // read data of the previous step is consumed this cycle
   assign acc_in = (rdv_ff && query_ff) ? (acc_ff + rd_data) : acc_ff;

   always_comb begin
      if (cmd.clear) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = rdv_ff && !query_ff;
         ram_waddr = wr_addr_ff;
         ram_wdata = rd_data + delta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         rdv_ff <= cmd.step;
         if (cmd.clear) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load) begin
         query_ff <= req_operation;
         delta_ff <= SUM_W'(req_delta);
         acc_ff   <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      if (cmd.step) begin
         wr_addr_ff <= rd_addr;
      end
      if (cmd.out_load) begin
         rsp_sum_ff <= acc_in;
      end
   end

   fpst_ram #(
      .WIDTH (SUM_W),
      .DEPTH (TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.clear_done = (clr_ff == AddrTop);
   assign status.walk_done  = (pos_ff == '0) || (!query_ff && (pos_ff > PtrTop));
   assign status.is_query   = query_ff;
   assign rsp_prefix_sum    = rsp_sum_ff;

endmodule

// ===== rtl/fenwick_prefix_sum_table_unit.sv =====
// top level: binary indexed tree of signed partial sums with update and prefix query
//
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   req_operation, req_position, req_delta
//  rsp       out        rsp_valid/rsp_stall   rsp_prefix_sum (queries only)
//
// an item walks one table entry per cycle via the single ram read port, update write overlapped
// after reset the table is swept to zero, one entry per cycle, req stalled
// a new beat is taken while a finished sum waits in the response register; a query only
// holds at its end when that register is still full and stalled
module fenwick_prefix_sum_table_unit
   import fpst_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DELTA_W-1:0] req_delta,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SUM_W-1:0]   rsp_prefix_sum
);

   cmd_type    cmd;
   status_type status;

   fpst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fpst_dp #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_operation),
      .req_position   (req_position),
      .req_delta      (req_delta),
      .rsp_prefix_sum (rsp_prefix_sum)
   );

endmodule
